@@ rtl/bsvc_pkg.sv @@
package bsvc_pkg;

  localparam int MaxChildren = 16;
  localparam int SlotW = $clog2(MaxChildren);
  localparam int CntW = $clog2(MaxChildren + 1);

  localparam logic [2:0] RegRow0   = 3'd0;
  localparam logic [2:0] RegRow1   = 3'd1;
  localparam logic [2:0] RegRow2   = 3'd2;
  localparam logic [2:0] RegTrans  = 3'd3;
  localparam logic [2:0] RegOrigin = 3'd4;
  localparam logic [2:0] RegCount  = 3'd5;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // item passed from front to back through the queue
  typedef struct packed {
    logic               mode;
    logic [3:0]         child_index;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } item_t;

  typedef struct packed {
    logic [47:0]   row0;
    logic [47:0]   row1;
    logic [47:0]   row2;
    logic [47:0]   trans;
    logic [47:0]   origin;
    logic [CntW-1:0] count;
  } cfg_t;

  function automatic logic signed [15:0] fld(input logic [47:0] p, input int j);
    fld = p[16*j +: 16];
  endfunction

  function automatic logic signed [15:0] rsat(input logic signed [35:0] acc);
    logic signed [35:0] r;
    r = (acc + 36'sd8192) >>> 14;
    if (r > 36'sd32767) rsat = 16'sh7fff;
    else if (r < -36'sd32768) rsat = 16'sh8000;
    else rsat = r[15:0];
  endfunction

endpackage

@@ rtl/bsvc_queue.sv @@
module bsvc_queue
  import bsvc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (out_valid_o && out_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, in_valid_i && in_ready_o}
                     - {1'b0, out_valid_o && out_ready_i};
    end
  end
endmodule

@@ rtl/bsvc_front.sv @@
module bsvc_front
  import bsvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  output cfg_t       cfg_o
);
  // config registers, count clamped at write
  cfg_t cfg_q;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row0 <= 48'd16384;
      cfg_q.row1 <= 48'd16384 << 16;
      cfg_q.row2 <= 48'd16384 << 32;
      cfg_q.trans <= '0;
      cfg_q.origin <= '0;
      cfg_q.count <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRow0:   cfg_q.row0 <= cfg_data_i;
        RegRow1:   cfg_q.row1 <= cfg_data_i;
        RegRow2:   cfg_q.row2 <= cfg_data_i;
        RegTrans:  cfg_q.trans <= cfg_data_i;
        RegOrigin: cfg_q.origin <= cfg_data_i;
        RegCount:  cfg_q.count <= (cfg_data_i[4:0] > 5'(MaxChildren)) ?
                                  CntW'(MaxChildren) : CntW'(cfg_data_i[4:0]);
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/bsvc_back.sv @@
module bsvc_back
  import bsvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       keep_o,
  output logic [15:0] lx_o, ly_o, lz_o, lnx_o, lny_o, lnz_o
);
  typedef enum logic [2:0] {SIdle, SMac, SRnd, SRead, SDot, SCmp, SOut} state_e;
  state_e state_q;

  logic [47:0] tab_q [MaxChildren];
  item_t it_q;
  logic [1:0] j_q, i_q;
  logic signed [35:0] ap_q, an_q;
  logic signed [15:0] lp_q [3];
  logic signed [15:0] ln_q [3];
  logic [CntW-1:0] k_q;
  logic [47:0] ent_q;
  logic signed [35:0] dot_q, sq_q;
  logic keep_q;

  logic signed [15:0] vi, ni, mij;
  logic signed [16:0] bb, dd;
  always_comb begin
    unique case (i_q)
      2'd0: begin vi = it_q.px; ni = it_q.nx; mij = fld(cfg_i.row0, int'(j_q)); end
      2'd1: begin vi = it_q.py; ni = it_q.ny; mij = fld(cfg_i.row1, int'(j_q)); end
      default: begin vi = it_q.pz; ni = it_q.nz; mij = fld(cfg_i.row2, int'(j_q)); end
    endcase
    bb = 17'(fld(ent_q, int'(i_q))) - 17'(fld(cfg_i.origin, int'(i_q)));
    dd = 17'(lp_q[i_q]) - 17'(fld(cfg_i.origin, int'(i_q)));
  end

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = state_q == SOut;
  assign keep_o = keep_q;
  assign lx_o = lp_q[0]; assign ly_o = lp_q[1]; assign lz_o = lp_q[2];
  assign lnx_o = ln_q[0]; assign lny_o = ln_q[1]; assign lnz_o = ln_q[2];

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i && item_i.mode == ModeLoad)
      tab_q[item_i.child_index[SlotW-1:0]] <= {item_i.pz, item_i.py, item_i.px};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      i_q <= '0; j_q <= '0; k_q <= '0; keep_q <= 1'b1;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i && item_i.mode == ModeQuery) begin
          it_q <= item_i; i_q <= '0; j_q <= '0;
          ap_q <= '0; an_q <= '0;
          state_q <= SMac;
        end
        SMac: begin
          if (i_q == 2'd0) begin
            ap_q <= 36'(fld(cfg_i.trans, int'(j_q))) * 36'sd16384 + 36'(vi * mij);
            an_q <= 36'(ni * mij);
          end else begin
            ap_q <= ap_q + 36'(vi * mij);
            an_q <= an_q + 36'(ni * mij);
          end
          if (i_q == 2'd2) begin i_q <= '0; state_q <= SRnd; end
          else i_q <= i_q + 2'd1;
        end
        SRnd: begin
          lp_q[j_q] <= rsat(ap_q);
          ln_q[j_q] <= rsat(an_q);
          if (j_q == 2'd2) begin
            k_q <= '0; keep_q <= 1'b1; state_q <= SRead;
          end else begin
            j_q <= j_q + 2'd1; state_q <= SMac;
          end
        end
        SRead: begin
          if (k_q == cfg_i.count || !keep_q) state_q <= SOut;
          else begin
            ent_q <= tab_q[k_q[SlotW-1:0]];
            i_q <= '0; dot_q <= '0; sq_q <= '0; state_q <= SDot;
          end
        end
        SDot: begin
          dot_q <= dot_q + 36'(dd * bb);
          sq_q  <= sq_q + 36'(bb * bb);
          if (i_q == 2'd2) state_q <= SCmp;
          else i_q <= i_q + 2'd1;
        end
        SCmp: begin
          // 20*dot in [sq, 19*sq]
          if (42'(dot_q) * 42'sd20 < 42'(sq_q) ||
              42'(dot_q) * 42'sd20 > 42'(sq_q) * 42'sd19) keep_q <= 1'b0;
          k_q <= k_q + 1'b1;
          state_q <= SRead;
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

@@ rtl/bone_segment_vertex_cull.sv @@
// channel | direction | handshake
// input   | in        | in_valid_i / in_ready_o
// result  | out       | out_valid_o / out_ready_i
// config  | in        | cfg_we_i, no wait
// a load writes the child table while the back end is idle; a query runs through
// the shared multiply-accumulate and the one-entry-per-step table walk
// two-entry queue lets the front accept while the back works or waits on output
// reset clears control and config; the child table is not cleared
module bone_segment_vertex_cull
  import bsvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  child_index_i,
  input  logic signed [15:0] pos_x_i, pos_y_i, pos_z_i,
  input  logic signed [15:0] norm_x_i, norm_y_i, norm_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        keep_o,
  output logic signed [15:0] local_x_o, local_y_o, local_z_o,
  output logic signed [15:0] local_nx_o, local_ny_o, local_nz_o
);
  cfg_t  cfg;
  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item = '{mode: mode_i, child_index: child_index_i, px: pos_x_i, py: pos_y_i,
                     pz: pos_z_i, nx: norm_x_i, ny: norm_y_i, nz: norm_z_i};

  // front: config registers
  bsvc_front u_front (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg));

  // queue decoupling accept from execution
  bsvc_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  // back: transform and segment tests
  bsvc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i(q_valid), .in_ready_o(q_ready),
    .item_i(q_item), .out_valid_o, .out_ready_i, .keep_o,
    .lx_o(local_x_o), .ly_o(local_y_o), .lz_o(local_z_o),
    .lnx_o(local_nx_o), .lny_o(local_ny_o), .lnz_o(local_nz_o)
  );
endmodule

@@ rtl/bsvc_checker.sv @@
module bsvc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic keep_o,
  input logic [15:0] local_x_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(keep_o) && $stable(local_x_o))
    else $error("result changed while stalled");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result after reset");
endmodule

bind bone_segment_vertex_cull bsvc_checker u_chk (.*);
